// File: rtl/prp_pkg.sv
// Shared constants, types and the arctangent table of the point rotation block.
`default_nettype none

package prp_pkg;

    localparam int COORD_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int ANG_W     = 18;   // angle register, degrees * 256
    localparam int RED_W     = 19;   // angle during turn reduction
    localparam int Z_W       = 25;   // residual angle, 2^-16 degree
    localparam int CS_W      = 19;   // cosine and sine, Q2.16
    localparam int ATAN_W    = 23;
    localparam int FRAC_BITS = 16;
    localparam int ANG_SHIFT = 8;    // 2^-8 degree to 2^-16 degree
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic signed [RED_W-1:0] FULL_TURN    = 19'sd92160;
    localparam logic signed [RED_W-1:0] HALF_TURN    = 19'sd46080;
    localparam logic signed [RED_W-1:0] QUARTER_TURN = 19'sd23040;

    // 1/K of the CORDIC gain in Q2.16
    localparam logic signed [CS_W-1:0] CORDIC_GAIN_INV = 19'sd39797;

    typedef enum logic [1:0] {
        REG_ANGLE   = 2'd0,
        REG_PIVOT_X = 2'd1,
        REG_PIVOT_Y = 2'd2
    } reg_idx_t;

    // Vector rotated by the CORDIC chain
    typedef struct packed {
        logic                   flip;   // half turn folded out: negate cos and sin
        logic signed [CS_W-1:0] x;
        logic signed [CS_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_vec_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic [ATAN_W-1:0] atan_q16(input int unsigned idx);
        logic [ATAN_W-1:0] val;
        case (idx)
            0:       val = 23'd2949120;
            1:       val = 23'd1740967;
            2:       val = 23'd919879;
            3:       val = 23'd466945;
            4:       val = 23'd234379;
            5:       val = 23'd117304;
            6:       val = 23'd58666;
            7:       val = 23'd29335;
            8:       val = 23'd14668;
            9:       val = 23'd7334;
            10:      val = 23'd3667;
            11:      val = 23'd1833;
            12:      val = 23'd917;
            13:      val = 23'd458;
            14:      val = 23'd229;
            15:      val = 23'd115;
            16:      val = 23'd57;
            17:      val = 23'd29;
            18:      val = 23'd14;
            19:      val = 23'd7;
            20:      val = 23'd4;
            21:      val = 23'd2;
            22:      val = 23'd1;
            default: val = 23'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// File: rtl/prp_point_if.sv
// Request channel carrying one vertex to rotate.
`default_nettype none

interface prp_point_if
    import prp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);

endinterface

`default_nettype wire

// File: rtl/prp_result_if.sv
// Result channel carrying one rotated vertex and its clip flag.
`default_nettype none

interface prp_result_if
    import prp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] rotated_x;
    logic signed [COORD_WIDTH-1:0] rotated_y;
    logic                          clipped;

    modport source (output valid, output rotated_x, output rotated_y, output clipped,
                    input ready);
    modport sink   (input valid, input rotated_x, input rotated_y, input clipped,
                    output ready);

endinterface

`default_nettype wire

// File: rtl/prp_cordic_stage.sv
// One registered CORDIC micro-rotation with its own valid/ready stage control.
`default_nettype none

module prp_cordic_stage
    import prp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int STAGE       = 0
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire cordic_vec_t                 in_vec,
    input  wire logic signed [COORD_WIDTH:0] in_dx,
    input  wire logic signed [COORD_WIDTH:0] in_dy,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output cordic_vec_t                      out_vec,
    output logic signed [COORD_WIDTH:0]      out_dx,
    output logic signed [COORD_WIDTH:0]      out_dy
);

    localparam logic signed [Z_W-1:0] ANGLE_STEP = Z_W'(atan_q16(STAGE));

    logic                         valid_reg;
    cordic_vec_t                  vec_reg;
    cordic_vec_t                  vec_next;
    logic signed [COORD_WIDTH:0]  dx_reg;
    logic signed [COORD_WIDTH:0]  dy_reg;
    logic signed [CS_W-1:0]       x_sh;
    logic signed [CS_W-1:0]       y_sh;

    // rotate towards zero residual angle
    always_comb
    begin
        x_sh          = $signed(in_vec.x) >>> STAGE;
        y_sh          = $signed(in_vec.y) >>> STAGE;
        vec_next.flip = in_vec.flip;
        if (!in_vec.z[Z_W-1])
        begin
            vec_next.x = $signed(in_vec.x) - y_sh;
            vec_next.y = $signed(in_vec.y) + x_sh;
            vec_next.z = $signed(in_vec.z) - ANGLE_STEP;
        end
        else
        begin
            vec_next.x = $signed(in_vec.x) + y_sh;
            vec_next.y = $signed(in_vec.y) - x_sh;
            vec_next.z = $signed(in_vec.z) + ANGLE_STEP;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            vec_reg <= vec_next;
            dx_reg  <= in_dx;
            dy_reg  <= in_dy;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_dx    = dx_reg;
    assign out_dy    = dy_reg;

endmodule

`default_nettype wire

// File: rtl/point_rotation_about_pivot.sv
// Top level: rotates a stream of vertices about a configured pivot by a configured angle.
//
// Use: write the angle (degrees * 256, counterclockwise positive) at byte 0, pivot x at
// byte 4 and pivot y at byte 8 through the APB port, while no request is in flight.
// Each request on point_in carries one vertex; result_out returns the vertex rotated
// about the pivot, truncated toward zero, saturated to the signed coordinate range,
// with clipped set when either coordinate was saturated.
// The path has CORDIC_STAGES + 4 register stages: one entry stage reduces the angle and
// forms the offset from the pivot, one stage per CORDIC micro-rotation, then a product
// stage, a sum stage and the output register. One request is taken every cycle while
// the output is not stalled; the unrolled CORDIC chain with one micro-rotation per stage
// sets that figure.
// Reset clears every stage valid bit and sets angle and pivots to zero.
// When the receiver stalls the output register holds its result, and each stage holds
// only while the stage after it is full, so bubbles close up; point_in.ready falls only
// once every stage holds a request. Nothing is lost or repeated across a stall.
`default_nettype none

module point_rotation_about_pivot
    import prp_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    prp_point_if.sink               point_in,
    prp_result_if.source            result_out
);

    localparam int DW = COORD_WIDTH + 1;        // offset from pivot
    localparam int PW = DW + CS_W;              // one product
    localparam int SW = PW + 2;                 // pivot plus two products, Q16
    localparam int QW = SW - FRAC_BITS;         // integer part of the sum
    localparam logic signed [SW-1:0] ROUND_BIAS = SW'((1 << FRAC_BITS) - 1);

    // ---------------------------------------------------------------- configuration
    logic signed [ANG_W-1:0]       angle_reg;
    logic signed [COORD_WIDTH-1:0] pivot_x_reg;
    logic signed [COORD_WIDTH-1:0] pivot_y_reg;
    logic                          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Register index sits in the word address; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg   <= '0;
            pivot_x_reg <= '0;
            pivot_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_ANGLE:   angle_reg   <= pwdata[ANG_W-1:0];
                REG_PIVOT_X: pivot_x_reg <= pwdata[COORD_WIDTH-1:0];
                REG_PIVOT_Y: pivot_y_reg <= pwdata[COORD_WIDTH-1:0];
                default:     ;
            endcase
        end
    end

    // Read back sign-extended to the data width.
    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_ANGLE:   prdata = PDATA_W'(angle_reg);
            REG_PIVOT_X: prdata = PDATA_W'(pivot_x_reg);
            REG_PIVOT_Y: prdata = PDATA_W'(pivot_y_reg);
            default:     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- stage chain wiring
    wire              valid_arr [0:CORDIC_STAGES];
    wire              ready_arr [0:CORDIC_STAGES];
    wire cordic_vec_t vec_arr   [0:CORDIC_STAGES];
    wire logic signed [DW-1:0] dx_arr [0:CORDIC_STAGES];
    wire logic signed [DW-1:0] dy_arr [0:CORDIC_STAGES];

    // ---------------------------------------------------------------- entry stage
    // Bring the angle into [-180, 180) degrees, then fold it into [-90, 90] by a half
    // turn, remembering to negate cos and sin. Only one correction is ever needed since
    // the register stays below one and a half turns in either direction.
    logic                    e_valid_reg;
    cordic_vec_t             e_vec_reg;
    cordic_vec_t             e_vec_next;
    logic signed [DW-1:0]    e_dx_reg;
    logic signed [DW-1:0]    e_dy_reg;
    logic signed [RED_W-1:0] ang_ext;
    logic signed [RED_W-1:0] ang_turn;
    logic signed [RED_W-1:0] ang_fold;
    logic                    ang_flip;
    logic                    in_ready;

    always_comb
    begin
        ang_ext = RED_W'(angle_reg);
        if (ang_ext >= HALF_TURN)
        begin
            ang_turn = ang_ext - FULL_TURN;
        end
        else if (ang_ext < -HALF_TURN)
        begin
            ang_turn = ang_ext + FULL_TURN;
        end
        else
        begin
            ang_turn = ang_ext;
        end

        if (ang_turn > QUARTER_TURN)
        begin
            ang_fold = ang_turn - HALF_TURN;
            ang_flip = 1'b1;
        end
        else if (ang_turn < -QUARTER_TURN)
        begin
            ang_fold = ang_turn + HALF_TURN;
            ang_flip = 1'b1;
        end
        else
        begin
            ang_fold = ang_turn;
            ang_flip = 1'b0;
        end

        e_vec_next.flip = ang_flip;
        e_vec_next.x    = CORDIC_GAIN_INV;
        e_vec_next.y    = '0;
        e_vec_next.z    = Z_W'(ang_fold) <<< ANG_SHIFT;
    end

    assign in_ready       = !e_valid_reg || ready_arr[0];
    assign point_in.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            e_valid_reg <= point_in.valid;
        end
    end

    // Pivots come from registers; the user must change them only while idle (unchecked).
    always_ff @(posedge clk)
    begin
        if (point_in.valid && in_ready)
        begin
            e_vec_reg <= e_vec_next;
            e_dx_reg  <= DW'(point_in.point_x) - DW'(pivot_x_reg);
            e_dy_reg  <= DW'(point_in.point_y) - DW'(pivot_y_reg);
        end
    end

    assign valid_arr[0] = e_valid_reg;
    assign vec_arr[0]   = e_vec_reg;
    assign dx_arr[0]    = e_dx_reg;
    assign dy_arr[0]    = e_dy_reg;

    // ---------------------------------------------------------------- CORDIC chain
    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        prp_cordic_stage #(
            .COORD_WIDTH (COORD_WIDTH),
            .STAGE       (k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_arr[k]),
            .in_ready  (ready_arr[k]),
            .in_vec    (vec_arr[k]),
            .in_dx     (dx_arr[k]),
            .in_dy     (dy_arr[k]),
            .out_valid (valid_arr[k+1]),
            .out_ready (ready_arr[k+1]),
            .out_vec   (vec_arr[k+1]),
            .out_dx    (dx_arr[k+1]),
            .out_dy    (dy_arr[k+1])
        );
    end

    // ---------------------------------------------------------------- product stage
    logic                   m_valid_reg;
    logic                   m_ready;
    logic                   s_ready;
    logic                   o_ready;
    logic signed [CS_W-1:0] cos_v;
    logic signed [CS_W-1:0] sin_v;
    logic signed [PW-1:0]   xc_reg;
    logic signed [PW-1:0]   ys_reg;
    logic signed [PW-1:0]   xs_reg;
    logic signed [PW-1:0]   yc_reg;

    always_comb
    begin
        if (vec_arr[CORDIC_STAGES].flip)
        begin
            cos_v = -$signed(vec_arr[CORDIC_STAGES].x);
            sin_v = -$signed(vec_arr[CORDIC_STAGES].y);
        end
        else
        begin
            cos_v = vec_arr[CORDIC_STAGES].x;
            sin_v = vec_arr[CORDIC_STAGES].y;
        end
    end

    assign m_ready                  = !m_valid_reg || s_ready;
    assign ready_arr[CORDIC_STAGES] = m_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (m_ready)
        begin
            m_valid_reg <= valid_arr[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_arr[CORDIC_STAGES] && m_ready)
        begin
            xc_reg <= PW'(dx_arr[CORDIC_STAGES]) * PW'(cos_v);
            ys_reg <= PW'(dy_arr[CORDIC_STAGES]) * PW'(sin_v);
            xs_reg <= PW'(dx_arr[CORDIC_STAGES]) * PW'(sin_v);
            yc_reg <= PW'(dy_arr[CORDIC_STAGES]) * PW'(cos_v);
        end
    end

    // ---------------------------------------------------------------- sum stage
    // Form pivot + rotated offset exactly in Q16.
    logic                 s_valid_reg;
    logic signed [SW-1:0] sx_reg;
    logic signed [SW-1:0] sy_reg;

    assign s_ready = !s_valid_reg || o_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            s_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_valid_reg && s_ready)
        begin
            sx_reg <= (SW'(pivot_x_reg) <<< FRAC_BITS) + SW'(xc_reg) - SW'(ys_reg);
            sy_reg <= (SW'(pivot_y_reg) <<< FRAC_BITS) + SW'(xs_reg) + SW'(yc_reg);
        end
    end

    // ---------------------------------------------------------------- output stage
    // Truncate toward zero (bias negative sums before the shift), then saturate.
    logic                          o_valid_reg;
    logic signed [COORD_WIDTH-1:0] rx_reg;
    logic signed [COORD_WIDTH-1:0] ry_reg;
    logic                          clip_reg;
    logic signed [SW-1:0]          adj_x;
    logic signed [SW-1:0]          adj_y;
    logic        [QW-1:0]          qx;
    logic        [QW-1:0]          qy;
    logic                          ovf_x;
    logic                          ovf_y;
    logic signed [COORD_WIDTH-1:0] rx_next;
    logic signed [COORD_WIDTH-1:0] ry_next;

    always_comb
    begin
        adj_x = sx_reg + (sx_reg[SW-1] ? ROUND_BIAS : SW'(0));
        adj_y = sy_reg + (sy_reg[SW-1] ? ROUND_BIAS : SW'(0));
        qx    = adj_x[SW-1:FRAC_BITS];
        qy    = adj_y[SW-1:FRAC_BITS];

        // in range when every bit above the coordinate sign matches it
        ovf_x = !((&qx[QW-1:COORD_WIDTH-1]) || !(|qx[QW-1:COORD_WIDTH-1]));
        ovf_y = !((&qy[QW-1:COORD_WIDTH-1]) || !(|qy[QW-1:COORD_WIDTH-1]));

        if (!ovf_x)
        begin
            rx_next = qx[COORD_WIDTH-1:0];
        end
        else if (qx[QW-1])
        begin
            rx_next = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end
        else
        begin
            rx_next = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end

        if (!ovf_y)
        begin
            ry_next = qy[COORD_WIDTH-1:0];
        end
        else if (qy[QW-1])
        begin
            ry_next = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end
        else
        begin
            ry_next = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    end

    assign o_ready = !o_valid_reg || result_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_ready)
        begin
            o_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid_reg && o_ready)
        begin
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            clip_reg <= ovf_x || ovf_y;
        end
    end

    assign result_out.valid     = o_valid_reg;
    assign result_out.rotated_x = rx_reg;
    assign result_out.rotated_y = ry_reg;
    assign result_out.clipped   = clip_reg;

endmodule

`default_nettype wire
